[hdl/i2ctxq_pkg.sv]
// Shared types and constants for the I2C transmit packet queue.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package i2ctxq_pkg;

    // Item kinds on the input channel
    localparam logic MODE_BYTE = 1'b0;   // packet byte pushed
    localparam logic MODE_DONE = 1'b1;   // bus transfer complete

    // Target address mask (7-bit I2C address)
    localparam logic [6:0] ADDR_MASK = 7'h7F;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted input item
        logic exec;      // first processing step of the item
        logic cmpl;      // remove the head packet after a completion
        logic issue;     // issue the descriptor of the new head packet
        logic load;      // move the result into the output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mode;      // kind of the item being processed
        logic enabled;   // queue enable register
        logic more;      // packets remain after the removal in progress
        logic out_free;  // output register can take a result
    } t_ctrl_sts;

endpackage

[hdl/i2c_tx_packet_queue_unit.sv]
// Top level of the I2C transmit packet queue: controller plus datapath.
// Depends on i2ctxq_pkg, i2ctxq_ctrl and i2ctxq_dpath.
`timescale 1ns / 1ps

// Transmit packet queue in front of an I2C master. Each input transfer is a
// packet byte or a bus-complete event; each produces exactly one result
// transfer with a descriptor (when one is issued) and the queue status.
// Items are handled one at a time: a packet byte or a completion while
// disabled passes through the EXEC and LOAD states to the output register,
// an enabled completion through EXEC, CMPL and LOAD, and through ISSUE
// before LOAD when the next head descriptor is issued. The input stalls
// until the result is loaded; the next item is taken in the IDLE state that
// follows. The CMPL step removes the head packet and ISSUE then issues the
// new head once its descriptor has come through the registered read port of
// the descriptor ring. A stalled output holds the LOAD state. The queue
// enable register may be written only while no item is in progress; writing
// it clears the packet count, and also the byte count when enabling.

module i2c_tx_packet_queue_unit #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_last,
    input  logic [7:0] i_packet_length,
    input  logic [6:0] i_device_address,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_start_valid,
    output logic [7:0] o_xfer_offset,
    output logic [7:0] o_xfer_length,
    output logic [6:0] o_xfer_device,
    output logic       o_overflow_flag,
    output logic       o_bus_free,
    output logic [7:0] o_queued_packets,
    output logic [7:0] o_queued_bytes
);
    import i2ctxq_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    i2ctxq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    i2ctxq_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_byte_last      (i_byte_last),
        .i_packet_length  (i_packet_length),
        .i_device_address (i_device_address),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_start_valid    (o_start_valid),
        .o_xfer_offset    (o_xfer_offset),
        .o_xfer_length    (o_xfer_length),
        .o_xfer_device    (o_xfer_device),
        .o_overflow_flag  (o_overflow_flag),
        .o_bus_free       (o_bus_free),
        .o_queued_packets (o_queued_packets),
        .o_queued_bytes   (o_queued_bytes),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

[hdl/i2ctxq_ctrl.sv]
// Sequencing controller for the I2C transmit packet queue.
// Depends on i2ctxq_pkg (command and status structs, item kinds).
`timescale 1ns / 1ps

module i2ctxq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2ctxq_pkg::t_ctrl_sts i_sts,
    output i2ctxq_pkg::t_ctrl_cmd o_cmd
);
    import i2ctxq_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_CMPL  = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.mode == MODE_DONE && i_sts.enabled) begin
                    n_state = ST_CMPL;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_CMPL: begin
                o_cmd.cmpl = 1'b1;
                n_state    = i_sts.more ? ST_ISSUE : ST_LOAD;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/i2ctxq_dpath.sv]
// Datapath of the I2C transmit packet queue: rings, pointers, counters,
// result and output registers. Depends on i2ctxq_pkg.
`timescale 1ns / 1ps

module i2ctxq_dpath #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    // input item
    input  logic                  i_mode,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_byte_last,
    input  logic [7:0]            i_packet_length,
    input  logic [6:0]            i_device_address,
    // output channel
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_start_valid,
    output logic [7:0]            o_xfer_offset,
    output logic [7:0]            o_xfer_length,
    output logic [6:0]            o_xfer_device,
    output logic                  o_overflow_flag,
    output logic                  o_bus_free,
    output logic [7:0]            o_queued_packets,
    output logic [7:0]            o_queued_bytes,
    // controller
    input  i2ctxq_pkg::t_ctrl_cmd i_cmd,
    output i2ctxq_pkg::t_ctrl_sts o_sts
);
    import i2ctxq_pkg::*;

    localparam int IW = $clog2(BUFFER_BYTES);
    localparam int SW = ((IW > 8) ? IW : 8) + 1;
    localparam logic [SW-1:0] BUF_S = SW'(BUFFER_BYTES);
    localparam logic [IW:0]   BUF_I = (IW + 1)'(BUFFER_BYTES);
    localparam logic [IW-1:0] ONE_I = IW'(1);

    // Ring add of two in-range indexes
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= BUF_I) begin
            s = s - BUF_I;
        end
        return s[IW-1:0];
    endfunction

    // Ring advance by a byte length that is below the buffer size
    function automatic logic [IW-1:0] wrap_len(input logic [IW-1:0] a,
                                               input logic [7:0]    l);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(l);
        if (s >= BUF_S) begin
            s = s - BUF_S;
        end
        return s[IW-1:0];
    endfunction

    // Low byte of an index-wide value
    function automatic logic [7:0] low8(input logic [IW-1:0] v);
        logic [IW+7:0] w;
        w = (IW + 8)'(v);
        return w[7:0];
    endfunction

    // Storage
    logic [7:0] byte_store   [BUFFER_BYTES];
    logic [7:0] length_ring  [BUFFER_BYTES];
    logic [6:0] address_ring [BUFFER_BYTES];

    // Captured item
    logic          r_mode;
    logic [7:0]    r_data;
    logic          r_last;
    logic [7:0]    r_plen;
    logic [6:0]    r_addr;

    // Queue state
    logic          r_enabled;
    logic [IW-1:0] r_byte_head;
    logic [IW-1:0] r_pkt_head;
    logic [IW-1:0] n_pkt_head;
    logic [IW-1:0] r_pkt_cnt;
    logic [IW-1:0] r_byte_cnt;
    logic [7:0]    r_bip;
    logic          r_dropping;
    logic          r_overflow;
    logic          r_busy;
    logic [7:0]    r_cur_len;
    logic [6:0]    r_cur_addr;
    logic [IW-1:0] r_cur_start;
    logic [IW-1:0] r_wr_ptr;

    // Head descriptor read port
    logic [7:0]    r_rd_len;
    logic [6:0]    r_rd_addr;

    // Result of the item in progress
    logic          r_res_start;
    logic [7:0]    r_res_off;
    logic [7:0]    r_res_len;
    logic [6:0]    r_res_dev;

    // Output register
    logic          r_out_valid;
    logic          out_free;

    // Byte push decode
    logic          p_exec;
    logic          p_first;
    logic [7:0]    p_len;
    logic [IW-1:0] p_start;
    logic [SW-1:0] p_room;
    logic          p_drop;
    logic [7:0]    p_clen;
    logic [6:0]    p_caddr;
    logic [IW-1:0] p_wptr;
    logic [IW-1:0] p_cstart;
    logic [7:0]    p_rx;
    logic          p_end;
    logic [IW-1:0] p_slot;
    logic [IW-1:0] p_base;
    logic [IW-1:0] p_newbc;
    logic          p_commit;
    logic          p_issue;

    // Completion decode
    logic          c_nz;
    logic          c_under;
    logic [IW-1:0] c_pc;
    logic          c_more;

    // Byte push: first byte latches length, address and room check
    always_comb begin
        p_exec   = i_cmd.exec && (r_mode == MODE_BYTE) && r_enabled;
        p_first  = (r_bip == 8'd0);
        p_len    = (r_plen == 8'd0) ? 8'd1 : r_plen;
        p_start  = wrap_add(r_byte_head, r_byte_cnt);
        p_room   = SW'(r_byte_cnt) + SW'(p_len);
        p_drop   = p_first ? (p_room >= BUF_S) : r_dropping;
        p_clen   = p_first ? p_len : r_cur_len;
        p_caddr  = p_first ? (r_addr & ADDR_MASK) : r_cur_addr;
        p_wptr   = p_first ? p_start : r_wr_ptr;
        p_cstart = p_first ? p_start : r_cur_start;
        p_rx     = r_bip + 8'd1;
        p_end    = r_last || (p_rx >= p_clen);
        p_slot   = wrap_add(r_pkt_head, r_pkt_cnt);
        p_base   = (r_pkt_cnt == '0) ? '0 : r_byte_cnt;
        p_newbc  = IW'(SW'(p_base) + SW'(p_rx));
        p_commit = p_exec && p_end && !p_drop;
        p_issue  = p_commit && !r_busy && (r_pkt_cnt == '0);
    end

    // Completion: remove head packet, clear on inconsistent length
    always_comb begin
        c_nz    = (r_pkt_cnt != '0);
        c_under = (SW'(r_byte_cnt) < SW'(r_rd_len));
        c_pc    = (c_nz && !c_under) ? (r_pkt_cnt - ONE_I) : '0;
        c_more  = (c_pc != '0);
        n_pkt_head = r_pkt_head;
        if (i_cmd.cmpl && c_nz && !c_under) begin
            n_pkt_head = wrap_add(r_pkt_head, ONE_I);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.mode     = r_mode;
    assign o_sts.enabled  = r_enabled;
    assign o_sts.more     = c_more;
    assign o_sts.out_free = out_free;

    // Memories: byte ring write, descriptor ring write and registered read
    always_ff @(posedge i_clk) begin
        if (p_exec && !p_drop) begin
            byte_store[p_wptr] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_commit) begin
            length_ring[p_slot]  <= p_rx;
            address_ring[p_slot] <= p_caddr;
        end
        r_rd_len  <= length_ring[n_pkt_head];
        r_rd_addr <= address_ring[n_pkt_head];
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_data <= i_data_byte;
            r_last <= i_byte_last;
            r_plen <= i_packet_length;
            r_addr <= i_device_address;
        end
    end

    // Packet-in-progress payload
    always_ff @(posedge i_clk) begin
        if (p_exec && !p_end) begin
            r_cur_len   <= p_clen;
            r_cur_addr  <= p_caddr;
            r_cur_start <= p_cstart;
            r_wr_ptr    <= wrap_add(p_wptr, ONE_I);
        end
    end

    // Queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_byte_head <= '0;
            r_pkt_head  <= '0;
            r_pkt_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_bip       <= '0;
            r_dropping  <= 1'b0;
            r_overflow  <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_pkt_head <= n_pkt_head;
            if (i_cfg_we) begin
                r_enabled  <= i_cfg_data;
                r_pkt_cnt  <= '0;
                r_bip      <= '0;
                r_dropping <= 1'b0;
                if (i_cfg_data) begin
                    r_byte_cnt <= '0;
                end
            end else if (p_exec) begin
                r_overflow <= r_overflow | (p_first & p_drop);
                if (!p_end) begin
                    r_bip      <= p_rx;
                    r_dropping <= p_drop;
                end else begin
                    r_bip      <= '0;
                    r_dropping <= 1'b0;
                    if (!p_drop) begin
                        if (r_pkt_cnt == '0) begin
                            r_byte_head <= p_cstart;
                        end
                        r_pkt_cnt  <= r_pkt_cnt + ONE_I;
                        r_byte_cnt <= p_newbc;
                        if (p_issue) begin
                            r_busy <= 1'b1;
                        end
                    end
                end
            end else if (i_cmd.exec && (r_mode == MODE_DONE) && !r_enabled) begin
                // disabled completion only frees the bus
                r_busy <= 1'b0;
            end else if (i_cmd.cmpl) begin
                r_pkt_cnt <= c_pc;
                // empty queue afterwards: counts cleared, bus freed
                if (!c_more) begin
                    r_byte_cnt <= '0;
                    r_busy     <= 1'b0;
                end else begin
                    r_byte_cnt <= r_byte_cnt - IW'(r_rd_len);
                end
                if (c_nz && !c_under) begin
                    r_byte_head <= wrap_len(r_byte_head, r_rd_len);
                end
            end else if (i_cmd.issue) begin
                r_busy <= 1'b1;
            end
        end
    end

    // Result of the current item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_start <= 1'b0;
        end else if (i_cmd.capture) begin
            r_res_start <= 1'b0;
        end else if (p_issue || i_cmd.issue) begin
            r_res_start <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_off <= '0;
            r_res_len <= '0;
            r_res_dev <= '0;
        end else if (p_issue) begin
            r_res_off <= low8(p_cstart);
            r_res_len <= p_rx;
            r_res_dev <= p_caddr;
        end else if (i_cmd.issue) begin
            r_res_off <= low8(r_byte_head);
            r_res_len <= r_rd_len;
            r_res_dev <= r_rd_addr;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_start_valid    <= r_res_start;
            o_xfer_offset    <= r_res_off;
            o_xfer_length    <= r_res_len;
            o_xfer_device    <= r_res_dev;
            o_overflow_flag  <= r_overflow;
            o_bus_free       <= !r_busy;
            o_queued_packets <= low8(r_pkt_cnt);
            o_queued_bytes   <= low8(r_byte_cnt);
        end
    end

    assign o_out_valid = r_out_valid;

    // Queue invariants
    a_pkt_le_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt_cnt <= r_byte_cnt)
        else $error("packet count exceeds byte count");

    a_bytes_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_byte_cnt} < BUF_I)
        else $error("byte count reached buffer size");

    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_start |-> r_busy)
        else $error("descriptor issued with bus free");

    a_bip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bip != 8'd0) |-> (r_bip < r_cur_len))
        else $error("packet byte index past latched length");

endmodule
